// ===== rtl/qxm_pkg.sv =====
package qxm_pkg;

    localparam int RC_W   = 11;
    localparam int PWM_W  = 12;
    localparam int LIM_W  = 8;
    localparam int FLT_W  = 3;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 12;

    // divider geometry: quotient bits, divisor bits, quotient bits per stage
    localparam int DIV_QW  = 12;
    localparam int DIV_DW  = 11;
    localparam int DIV_SPS = 2;

    // signed mix width: throttle plus three adjustments of up to DIV_QW bits
    localparam int MIX_W  = 16;

    localparam logic [IDX_W-1:0] REG_RC_LOW      = 3'd0;
    localparam logic [IDX_W-1:0] REG_RC_HIGH     = 3'd1;
    localparam logic [IDX_W-1:0] REG_RC_CENTER   = 3'd2;
    localparam logic [IDX_W-1:0] REG_PWM_FLOOR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PWM_CEILING = 3'd4;
    localparam logic [IDX_W-1:0] REG_ADJ_LIMIT   = 3'd5;

    localparam logic [RC_W-1:0]  RST_RC_LOW      = 11'd172;
    localparam logic [RC_W-1:0]  RST_RC_HIGH     = 11'd1811;
    localparam logic [RC_W-1:0]  RST_RC_CENTER   = 11'd991;
    localparam logic [PWM_W-1:0] RST_PWM_FLOOR   = 12'd210;
    localparam logic [PWM_W-1:0] RST_PWM_CEILING = 12'd405;
    localparam logic [LIM_W-1:0] RST_ADJ_LIMIT   = 8'd25;

    // sideband that rides along the throttle divider
    typedef struct packed {
        logic             thr_low;
        logic             thr_high;
        logic [FLT_W-1:0] fault;
    } t_side;

endpackage

// ===== rtl/qxm_div.sv =====
module qxm_div #(
    parameter int QW  = qxm_pkg::DIV_QW,
    parameter int DW  = qxm_pkg::DIV_DW,
    parameter int SPS = qxm_pkg::DIV_SPS,
    parameter int TW  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [TW-1:0]    i_tag,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [TW-1:0]    o_tag
);
    localparam int STAGES = QW / SPS;

    logic [DW-1:0] s_rem [0:STAGES];
    logic [QW-1:0] s_low [0:STAGES];
    logic [DW-1:0] s_den [0:STAGES];
    logic [TW-1:0] s_tag [0:STAGES];
    logic          s_vld [0:STAGES];

    logic [DW-1:0] r_rem [0:STAGES-1];
    logic [QW-1:0] r_low [0:STAGES-1];
    logic [DW-1:0] r_den [0:STAGES-1];
    logic [TW-1:0] r_tag [0:STAGES-1];
    logic          r_vld [0:STAGES-1];

    // upper numerator bits start as the remainder, lower bits shift in
    assign s_rem[0] = i_num[DW+QW-1:QW];
    assign s_low[0] = i_num[QW-1:0];
    assign s_den[0] = i_den;
    assign s_tag[0] = i_tag;
    assign s_vld[0] = i_valid;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_low;

        always_comb begin
            logic [DW:0] t;
            n_rem = s_rem[s];
            n_low = s_low[s];
            for (int k = 0; k < SPS; k++) begin
                t = {n_rem, n_low[QW-1]};
                if (t >= {1'b0, s_den[s]}) begin
                    n_rem = DW'(t - {1'b0, s_den[s]});
                    n_low = {n_low[QW-2:0], 1'b1};
                end else begin
                    n_rem = t[DW-1:0];
                    n_low = {n_low[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= s_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_low[s] <= n_low;
            r_den[s] <= s_den[s];
            r_tag[s] <= s_tag[s];
        end

        assign s_rem[s+1] = r_rem[s];
        assign s_low[s+1] = r_low[s];
        assign s_den[s+1] = r_den[s];
        assign s_tag[s+1] = r_tag[s];
        assign s_vld[s+1] = r_vld[s];
    end

    assign o_valid = s_vld[STAGES];
    assign o_quo   = s_low[STAGES];
    assign o_tag   = s_tag[STAGES];

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_den[0] != '0)
        else $error("divider got a zero divisor");

    a_rem_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_rem[0] < r_den[0])
        else $error("partial remainder not below divisor");

    a_rem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] |-> r_rem[STAGES-1] < r_den[STAGES-1])
        else $error("final remainder not below divisor");

endmodule

// ===== rtl/qxm_mix.sv =====
module qxm_mix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [qxm_pkg::PWM_W-1:0]    i_thr,
    input  logic signed [qxm_pkg::MIX_W-1:0] i_adj_a,
    input  logic signed [qxm_pkg::MIX_W-1:0] i_adj_e,
    input  logic signed [qxm_pkg::MIX_W-1:0] i_adj_r,
    input  logic [qxm_pkg::FLT_W-1:0]    i_fault,
    input  logic [qxm_pkg::PWM_W-1:0]    i_floor,
    input  logic [qxm_pkg::PWM_W-1:0]    i_ceiling,
    output logic                         o_valid,
    output logic [qxm_pkg::PWM_W-1:0]    o_thr,
    output logic [qxm_pkg::PWM_W-1:0]    o_m1,
    output logic [qxm_pkg::PWM_W-1:0]    o_m2,
    output logic [qxm_pkg::PWM_W-1:0]    o_m3,
    output logic [qxm_pkg::PWM_W-1:0]    o_m4,
    output logic [qxm_pkg::FLT_W-1:0]    o_fault
);
    import qxm_pkg::*;

    typedef logic signed [MIX_W-1:0] t_mix;

    // stage a: raw x-mix sums
    logic       r_a_vld;
    t_mix       r_a_m [0:3];
    logic [PWM_W-1:0] r_a_thr, r_a_floor;
    logic [FLT_W-1:0] r_a_fault;

    // stage b: lifted sums
    logic       r_b_vld;
    t_mix       r_b_m [0:3];
    logic [PWM_W-1:0] r_b_thr, r_b_floor;
    logic [FLT_W-1:0] r_b_fault;

    // stage c: outputs
    logic       r_c_vld;
    logic [PWM_W-1:0] r_c_m [0:3];
    logic [PWM_W-1:0] r_c_thr;
    logic [FLT_W-1:0] r_c_fault;

    t_mix n_thr_s, n_min01, n_min23, n_min, n_lift, n_floor_s, n_ceil_s;

    assign n_thr_s = t_mix'({1'b0, i_thr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_m[0]  <= n_thr_s - i_adj_a - i_adj_e - i_adj_r;
        r_a_m[1]  <= n_thr_s + i_adj_a - i_adj_e + i_adj_r;
        r_a_m[2]  <= n_thr_s - i_adj_a + i_adj_e + i_adj_r;
        r_a_m[3]  <= n_thr_s + i_adj_a + i_adj_e - i_adj_r;
        r_a_thr   <= i_thr;
        r_a_floor <= i_floor;
        r_a_fault <= i_fault;
    end

    assign n_floor_s = t_mix'({1'b0, r_a_floor});
    assign n_min01   = (r_a_m[1] < r_a_m[0]) ? r_a_m[1] : r_a_m[0];
    assign n_min23   = (r_a_m[3] < r_a_m[2]) ? r_a_m[3] : r_a_m[2];
    assign n_min     = (n_min23 < n_min01) ? n_min23 : n_min01;
    assign n_lift    = (n_min < n_floor_s) ? n_floor_s - n_min : '0;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_b_m[i] <= r_a_m[i] + n_lift;
        end
        r_b_thr   <= r_a_thr;
        r_b_floor <= r_a_floor;
        r_b_fault <= r_a_fault;
    end

    // floor test first, but a floor above the ceiling does not win: lifted sums above the ceiling get the ceiling
    assign n_ceil_s = t_mix'({1'b0, i_ceiling});

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (r_b_m[i] < t_mix'({1'b0, r_b_floor})) begin
                r_c_m[i] <= r_b_floor;
            end else if (r_b_m[i] > n_ceil_s) begin
                r_c_m[i] <= i_ceiling;
            end else begin
                r_c_m[i] <= r_b_m[i][PWM_W-1:0];
            end
        end
        r_c_thr   <= r_b_thr;
        r_c_fault <= r_b_fault;
    end

    assign o_valid = r_c_vld;
    assign o_thr   = r_c_thr;
    assign o_m1    = r_c_m[0];
    assign o_m2    = r_c_m[1];
    assign o_m3    = r_c_m[2];
    assign o_m4    = r_c_m[3];
    assign o_fault = r_c_fault;

    a_lift_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> r_b_m[0] >= t_mix'({1'b0, r_b_floor}) &&
                    r_b_m[1] >= t_mix'({1'b0, r_b_floor}) &&
                    r_b_m[2] >= t_mix'({1'b0, r_b_floor}) &&
                    r_b_m[3] >= t_mix'({1'b0, r_b_floor}))
        else $error("lifted motor below floor");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> $past(r_b_vld))
        else $error("output without a lifted request");

    // a ceiling below the floor still wins once the sums are lifted
    a_out_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_c_m[0] >= $past(r_b_floor) || r_c_m[0] == i_ceiling) &&
                    (r_c_m[3] >= $past(r_b_floor) || r_c_m[3] == i_ceiling))
        else $error("clamped motor below floor");

endmodule

// ===== rtl/quad_x_motor_mixer_core.sv =====
// channel   | direction | ports                                   | handshake
// request   | in        | i_throttle_raw .. i_rudder_raw          | start, busy
// result    | out       | o_throttle_level, o_motor_*_pwm, o_range_fault | o_done
// config    | in        | i_cfg_idx, i_cfg_data                   | i_cfg_we
// one request per cycle while busy is low; each result passes these registered stages in order:
// prep, multiply, 6 divider stages (2 quotient bits each), mix, lift, clamp
// i_rst_n is synchronous; busy is high only during reset
// the receiver cannot stall: o_done is a one-cycle strobe
module quad_x_motor_mixer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [qxm_pkg::RC_W-1:0]    i_throttle_raw,
    input  logic [qxm_pkg::RC_W-1:0]    i_aileron_raw,
    input  logic [qxm_pkg::RC_W-1:0]    i_elevator_raw,
    input  logic [qxm_pkg::RC_W-1:0]    i_rudder_raw,
    input  logic                        i_cfg_we,
    input  logic [qxm_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [qxm_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_done,
    output logic [qxm_pkg::PWM_W-1:0]   o_throttle_level,
    output logic [qxm_pkg::PWM_W-1:0]   o_motor_one_pwm,
    output logic [qxm_pkg::PWM_W-1:0]   o_motor_two_pwm,
    output logic [qxm_pkg::PWM_W-1:0]   o_motor_three_pwm,
    output logic [qxm_pkg::PWM_W-1:0]   o_motor_four_pwm,
    output logic [qxm_pkg::FLT_W-1:0]   o_range_fault
);
    import qxm_pkg::*;

    localparam int NW = DIV_DW + DIV_QW;

    logic [RC_W-1:0]  r_rc_low, r_rc_high, r_rc_center;
    logic [PWM_W-1:0] r_pwm_floor, r_pwm_ceiling;
    logic [LIM_W-1:0] r_adj_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_low      <= RST_RC_LOW;
            r_rc_high     <= RST_RC_HIGH;
            r_rc_center   <= RST_RC_CENTER;
            r_pwm_floor   <= RST_PWM_FLOOR;
            r_pwm_ceiling <= RST_PWM_CEILING;
            r_adj_limit   <= RST_ADJ_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RC_LOW:      r_rc_low      <= i_cfg_data[RC_W-1:0];
                REG_RC_HIGH:     r_rc_high     <= i_cfg_data[RC_W-1:0];
                REG_RC_CENTER:   r_rc_center   <= i_cfg_data[RC_W-1:0];
                REG_PWM_FLOOR:   r_pwm_floor   <= i_cfg_data[PWM_W-1:0];
                REG_PWM_CEILING: r_pwm_ceiling <= i_cfg_data[PWM_W-1:0];
                REG_ADJ_LIMIT:   r_adj_limit   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic accept;
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // ---- stage 1: compares and differences
    logic [RC_W-1:0] ctl_raw [0:2];
    assign ctl_raw[0] = i_aileron_raw;
    assign ctl_raw[1] = i_elevator_raw;
    assign ctl_raw[2] = i_rudder_raw;

    logic             r1_vld;
    t_side            r1_side;
    logic [RC_W-1:0]  r1_x, r1_dx;
    logic [RC_W-1:0]  r1_mag  [0:2];
    logic [RC_W-1:0]  r1_span [0:2];
    logic             r1_neg  [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side.thr_low  <= i_throttle_raw <= r_rc_low;
        r1_side.thr_high <= i_throttle_raw >= r_rc_high;
        r1_x  <= i_throttle_raw - r_rc_low;
        r1_dx <= r_rc_high - i_throttle_raw;
        for (int c = 0; c < 3; c++) begin
            r1_side.fault[c] <= ctl_raw[c] < r_rc_low || ctl_raw[c] > r_rc_high;
            r1_neg[c] <= ctl_raw[c] < r_rc_center;
            if (ctl_raw[c] < r_rc_center) begin
                r1_mag[c]  <= r_rc_center - ctl_raw[c];
                r1_span[c] <= r_rc_center - r_rc_low;
            end else begin
                r1_mag[c]  <= ctl_raw[c] - r_rc_center;
                r1_span[c] <= r_rc_high - r_rc_center;
            end
        end
    end

    // ---- stage 2: numerators; floor*(D-x) + ceiling*x over D gives the linear map
    logic             r2_vld;
    t_side            r2_side;
    logic [NW-1:0]    r2_num [0:3];
    logic [RC_W-1:0]  r2_den [0:3];
    logic             r2_neg [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW:0] sum;
        sum = (NW+1)'(r_pwm_floor * r1_dx) + (NW+1)'(r_pwm_ceiling * r1_x);
        r2_side <= r1_side;
        if (r1_side.thr_low || r1_side.thr_high) begin
            r2_num[0] <= '0;
            r2_den[0] <= RC_W'(1);
        end else begin
            r2_num[0] <= sum[NW-1:0];
            r2_den[0] <= r1_x + r1_dx;
        end
        for (int c = 0; c < 3; c++) begin
            r2_neg[c] <= r1_neg[c];
            // zero adjustment on a fault or at center: keep the divisor nonzero
            if (r1_side.fault[c] || r1_mag[c] == '0) begin
                r2_num[c+1] <= '0;
                r2_den[c+1] <= RC_W'(1);
            end else begin
                r2_num[c+1] <= NW'(r1_mag[c] * r_adj_limit);
                r2_den[c+1] <= r1_span[c];
            end
        end
    end

    // ---- divider pipelines
    logic              d_vld;
    logic [DIV_QW-1:0] d_quo [0:3];
    t_side             d_side;
    logic              d_neg [0:2];
    logic              d_unused_vld [0:2];

    qxm_div #(.QW(DIV_QW), .DW(DIV_DW), .SPS(DIV_SPS), .TW($bits(t_side))) u_div_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   (r2_num[0]),
        .i_den   (r2_den[0]),
        .i_tag   (r2_side),
        .o_valid (d_vld),
        .o_quo   (d_quo[0]),
        .o_tag   (d_side)
    );

    for (genvar c = 0; c < 3; c++) begin : g_ctl
        qxm_div #(.QW(DIV_QW), .DW(DIV_DW), .SPS(DIV_SPS), .TW(1)) u_div_ctl (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r2_vld),
            .i_num   (r2_num[c+1]),
            .i_den   (r2_den[c+1]),
            .i_tag   (r2_neg[c]),
            .o_valid (d_unused_vld[c]),
            .o_quo   (d_quo[c+1]),
            .o_tag   (d_neg[c])
        );
    end

    logic [PWM_W-1:0]            m_thr;
    logic signed [MIX_W-1:0]     m_adj [0:2];

    always_comb begin
        if (d_side.thr_low) begin
            m_thr = r_pwm_floor;
        end else if (d_side.thr_high) begin
            m_thr = r_pwm_ceiling;
        end else begin
            m_thr = d_quo[0];
        end
        for (int c = 0; c < 3; c++) begin
            m_adj[c] = d_neg[c] ? -MIX_W'(d_quo[c+1]) : MIX_W'(d_quo[c+1]);
        end
    end

    qxm_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (d_vld),
        .i_thr     (m_thr),
        .i_adj_a   (m_adj[0]),
        .i_adj_e   (m_adj[1]),
        .i_adj_r   (m_adj[2]),
        .i_fault   (d_side.fault),
        .i_floor   (r_pwm_floor),
        .i_ceiling (r_pwm_ceiling),
        .o_valid   (o_done),
        .o_thr     (o_throttle_level),
        .o_m1      (o_motor_one_pwm),
        .o_m2      (o_motor_two_pwm),
        .o_m3      (o_motor_three_pwm),
        .o_m4      (o_motor_four_pwm),
        .o_fault   (o_range_fault)
    );

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld |-> (!d_side.fault[0] || d_quo[1] == '0) &&
                  (!d_side.fault[1] || d_quo[2] == '0) &&
                  (!d_side.fault[2] || d_quo[3] == '0))
        else $error("faulted channel produced an adjustment");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld == d_unused_vld[0] && d_vld == d_unused_vld[1] && d_vld == d_unused_vld[2])
        else $error("divider lanes out of step");

    a_adj_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld |-> d_quo[1] <= DIV_QW'(r_adj_limit) && d_quo[2] <= DIV_QW'(r_adj_limit) &&
                  d_quo[3] <= DIV_QW'(r_adj_limit))
        else $error("adjustment above limit");

endmodule
